FILE: sv/pfde_pkg.sv
`default_nettype none
package pfde_pkg;

  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 64;
  localparam logic [7:0] COL_OFFSET_RESET = 8'd2;
  localparam logic [7:0] HDR_HIGH_COL = 8'h10;
  localparam logic [7:0] HDR_PAGE_CMD = 8'hB0;
  localparam logic [7:0] BYTE_ONES    = 8'hFF;

  typedef enum logic [2:0] {
    REQ_PIXEL = 3'd0,
    REQ_FILL  = 3'd1,
    REQ_CLEAR = 3'd2,
    REQ_GLYPH = 3'd3,
    REQ_READ  = 3'd4
  } req_t;

  typedef enum logic [3:0] {
    ST_CLR_SWEEP,
    ST_IDLE,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_GLY_RD,
    ST_GLY_WR,
    ST_CLEAR,
    ST_HDR,
    ST_RD_BYTE,
    ST_RD_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture transaction fields
    logic sweep_init; // start clear sweep over the whole store
    logic sweep_step; // write sweep byte, advance
    logic rmw_rd;     // issue read of target byte
    logic rmw_wr;     // write modified byte
    logic fill_next;  // advance fill cursor
    logic gly_next;   // advance glyph row
    logic hdr_emit;   // put header in output register
    logic rd_issue;   // issue readout byte read
    logic rd_shift;   // shift in read byte
    logic word_emit;  // put data word in output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_done;
    logic fill_empty;
    logic fill_done;
    logic gly_done;
    logic byte_done;
    logic page_done;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

FILE: sv/pfde_datapath.sv
`default_nettype none
module pfde_datapath #(
  parameter int SCREEN_WIDTH  = pfde_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = pfde_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pfde_pkg::cmd_t   cmd,
  output pfde_pkg::stat_t       stat,
  input  wire logic             cfg_wr_en,
  input  wire logic [7:0]       cfg_wr_data,
  input  wire logic [7:0]       in_x_pos,
  input  wire logic [7:0]       in_y_pos,
  input  wire logic [7:0]       in_rect_width,
  input  wire logic [7:0]       in_rect_height,
  input  wire logic             in_set_on,
  input  wire logic [7:0]       in_top_bits,
  input  wire logic [7:0]       in_bottom_bits,
  input  wire logic             in_msb_first,
  input  wire logic [2:0]       in_page_index,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_item_kind,
  output logic [63:0]           out_payload,
  output logic                  out_last_item
);
  localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
  localparam int DEPTH      = PAGE_COUNT * SCREEN_WIDTH;
  localparam int AW         = $clog2(DEPTH);
  localparam int WPP        = (SCREEN_WIDTH + 7) / 8;
  localparam int WW         = (WPP > 1) ? $clog2(WPP) : 1;

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  logic [7:0] col_off_r;
  logic [7:0] x_r, y_r, xe_r, ye_r, row_r, col_r;
  logic [7:0] x_nxt, y_nxt, xe_nxt, ye_nxt, row_nxt, col_nxt;
  logic       on_r;
  logic [15:0] gly_r;   // glyph bits, bit k is row y+k
  logic [2:0] page_r;
  logic [AW:0] sweep_r;
  logic [7:0] sweep_val_r;
  logic [WW:0] word_r;
  logic [2:0]  byte_r;
  logic [55:0] acc_r;
  logic        out_valid_r, out_kind_r, out_last_r;
  logic [63:0] out_pay_r;

  // target addressing for read-modify-write
  logic [8:0]  tgt_row;
  logic [7:0]  tgt_col;
  logic [7:0]  wmask;
  logic [7:0]  wdata;
  logic        tgt_ok;
  logic [AW-1:0] tgt_addr;
  logic [AW-1:0] rd_addr;
  logic [15:0] gly_src;
  logic [7:0]  rd_byte;
  logic        rd_inrange;
  logic [8:0]  rd_col;

  // pixel bit order of glyph column
  always_comb begin
    gly_src = {in_bottom_bits, in_top_bits};
    if (in_msb_first) begin
      for (int k = 0; k < 8; k++) begin
        gly_src[k]     = in_top_bits[7-k];
        gly_src[k + 8] = in_bottom_bits[7-k];
      end
    end
  end

  // current row and column of the operation in flight
  always_comb begin
    tgt_col  = col_r;
    tgt_row  = {1'b0, row_r};
    tgt_ok   = ({1'b0, col_r} < 9'(SCREEN_WIDTH)) && (tgt_row < 9'(SCREEN_HEIGHT));
    tgt_addr = AW'(32'(tgt_row[8:3]) * SCREEN_WIDTH + 32'(tgt_col));
  end

  // single-bit mask for the current row
  always_comb begin
    wmask = '0;
    wdata = rd_data_r;
    wmask[row_r[2:0]] = 1'b1;
    if (on_r) wdata = rd_data_r | wmask;
    else      wdata = rd_data_r & ~wmask;
  end

  // readout source
  assign rd_col = 9'(32'(word_r) * 8) + 9'(byte_r);
  assign rd_inrange = (32'(page_r) < PAGE_COUNT) && (rd_col < 9'(SCREEN_WIDTH));
  assign rd_byte = rd_inrange ? rd_data_r : 8'h00;

  always_comb begin
    rd_addr = tgt_addr;
    if (cmd.rd_issue)
      rd_addr = AW'(32'(page_r) * SCREEN_WIDTH + 32'(rd_col));
  end

  // memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.sweep_step)
      mem[sweep_r[AW-1:0]] <= sweep_val_r;
    else if (cmd.rmw_wr && tgt_ok)
      mem[tgt_addr] <= wdata;
    if (cmd.rmw_rd || cmd.rd_issue)
      rd_data_r <= mem[rd_addr];
  end

  // operation registers
  always_comb begin
    x_nxt = x_r; y_nxt = y_r; xe_nxt = xe_r; ye_nxt = ye_r;
    row_nxt = row_r; col_nxt = col_r;
    if (cmd.load) begin
      x_nxt = in_x_pos; y_nxt = in_y_pos;
      xe_nxt = in_x_pos + in_rect_width;
      ye_nxt = in_y_pos + in_rect_height;
      row_nxt = in_y_pos; col_nxt = in_x_pos;
    end else if (cmd.fill_next) begin
      if (col_r + 8'd1 == xe_r || 9'(col_r) + 9'd1 >= 9'(SCREEN_WIDTH)) begin
        col_nxt = x_r;
        row_nxt = row_r + 8'd1;
      end else begin
        col_nxt = col_r + 8'd1;
      end
    end else if (cmd.gly_next) begin
      row_nxt = row_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; xe_r <= xe_nxt; ye_r <= ye_nxt;
    row_r <= row_nxt; col_r <= col_nxt;
    if (cmd.load) begin
      on_r   <= in_set_on;
      page_r <= in_page_index;
      gly_r  <= gly_src;
    end else if (cmd.gly_next) begin
      gly_r <= {1'b0, gly_r[15:1]};
    end
  end

  // clear sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
      sweep_val_r <= 8'h00;
    end else if (cmd.sweep_init) begin
      sweep_r <= '0;
      sweep_val_r <= on_r ? pfde_pkg::BYTE_ONES : 8'h00;
    end else if (cmd.sweep_step) begin
      sweep_r <= sweep_r + 1'b1;
    end
  end

  // readout word assembly
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
      byte_r <= '0;
    end else if (cmd.hdr_emit) begin
      word_r <= '0;
      byte_r <= '0;
    end else if (cmd.rd_shift) begin
      acc_r  <= {rd_byte, acc_r[55:8]};
      byte_r <= byte_r + 3'd1;
    end else if (cmd.word_emit) begin
      word_r <= word_r + 1'b1;
      byte_r <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.hdr_emit || cmd.word_emit || (out_valid_r && out_stall);
    end
    if (cmd.hdr_emit) begin
      out_kind_r <= 1'b0;
      out_last_r <= 1'b0;
      out_pay_r  <= {40'd0, pfde_pkg::HDR_PAGE_CMD | {5'd0, page_r},
                     pfde_pkg::HDR_HIGH_COL | {4'd0, col_off_r[7:4]},
                     {4'd0, col_off_r[3:0]}};
    end else if (cmd.word_emit) begin
      out_kind_r <= 1'b1;
      out_last_r <= (32'(word_r) == WPP - 1);
      out_pay_r  <= {rd_byte, acc_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) col_off_r <= pfde_pkg::COL_OFFSET_RESET;
    else if (cfg_wr_en) col_off_r <= cfg_wr_data;
  end

  assign out_valid     = out_valid_r;
  assign out_item_kind = out_kind_r;
  assign out_payload   = out_pay_r;
  assign out_last_item = out_last_r;

  // status; a glyph stops at row 255 since every later row is off screen
  always_comb begin
    stat.sweep_done = (32'(sweep_r) == DEPTH - 1);
    stat.fill_empty = (xe_r <= x_r) || (ye_r <= y_r) ||
                      (9'(x_r) >= 9'(SCREEN_WIDTH)) || (9'(y_r) >= 9'(SCREEN_HEIGHT));
    stat.fill_done  = (col_r + 8'd1 == xe_r || 9'(col_r) + 9'd1 >= 9'(SCREEN_WIDTH)) &&
                      (row_r + 8'd1 == ye_r || 9'(row_r) + 9'd1 >= 9'(SCREEN_HEIGHT));
    stat.gly_done   = (gly_r[15:1] == 15'd0) || (row_r == 8'hFF);
    stat.byte_done  = (byte_r == 3'd7);
    stat.page_done  = (32'(word_r) == WPP - 1);
    stat.out_busy   = out_valid_r && out_stall;
  end

  // sweep counter stays inside the store
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sweep_step |-> 32'(sweep_r) < DEPTH)
    else $error("sweep past end of store");
  // header and data word never issued together
  assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.hdr_emit && cmd.word_emit))
    else $error("two output sources at once");
  // output register not overwritten while stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(cmd.hdr_emit || cmd.word_emit))
    else $error("stalled result overwritten");
endmodule
`default_nettype wire

FILE: sv/pfde_ctrl.sv
`default_nettype none
module pfde_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [2:0]      in_req_type,
  input  wire logic [15:0]     gly_bits,
  input  wire logic [15:0]     gly_cur,
  input  wire pfde_pkg::stat_t stat,
  output pfde_pkg::cmd_t       cmd,
  output logic                 force_on
);
  pfde_pkg::state_t state_r, state_nxt;
  logic accept;
  logic is_sweep_first_r;

  assign in_stall = (state_r != pfde_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfde_pkg::ST_CLR_SWEEP: if (stat.sweep_done) state_nxt = pfde_pkg::ST_IDLE;
      pfde_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_req_type)
            pfde_pkg::REQ_PIXEL: state_nxt = pfde_pkg::ST_RMW_RD;
            pfde_pkg::REQ_FILL:  state_nxt = pfde_pkg::ST_FILL_RD;
            pfde_pkg::REQ_CLEAR: state_nxt = pfde_pkg::ST_CLEAR;
            pfde_pkg::REQ_GLYPH: state_nxt = (gly_bits != 16'd0) ?
                                   pfde_pkg::ST_GLY_RD : pfde_pkg::ST_IDLE;
            pfde_pkg::REQ_READ:  state_nxt = pfde_pkg::ST_HDR;
            default:             state_nxt = pfde_pkg::ST_IDLE;
          endcase
        end
      end
      pfde_pkg::ST_RMW_RD:  state_nxt = pfde_pkg::ST_RMW_WR;
      pfde_pkg::ST_RMW_WR:  state_nxt = pfde_pkg::ST_IDLE;
      pfde_pkg::ST_FILL_RD: state_nxt = stat.fill_empty ? pfde_pkg::ST_IDLE
                                                        : pfde_pkg::ST_FILL_WR;
      pfde_pkg::ST_FILL_WR: state_nxt = stat.fill_done ? pfde_pkg::ST_IDLE
                                                       : pfde_pkg::ST_FILL_RD;
      pfde_pkg::ST_GLY_RD:  state_nxt = pfde_pkg::ST_GLY_WR;
      pfde_pkg::ST_GLY_WR:  state_nxt = stat.gly_done ? pfde_pkg::ST_IDLE
                                                      : pfde_pkg::ST_GLY_RD;
      pfde_pkg::ST_CLEAR:   if (stat.sweep_done) state_nxt = pfde_pkg::ST_IDLE;
      pfde_pkg::ST_HDR:     if (!stat.out_busy) state_nxt = pfde_pkg::ST_RD_BYTE;
      pfde_pkg::ST_RD_BYTE: state_nxt = pfde_pkg::ST_RD_OUT;
      pfde_pkg::ST_RD_OUT: begin
        if (!stat.byte_done) state_nxt = pfde_pkg::ST_RD_BYTE;
        else if (!stat.out_busy)
          state_nxt = stat.page_done ? pfde_pkg::ST_IDLE : pfde_pkg::ST_RD_BYTE;
      end
      default: state_nxt = pfde_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    force_on = 1'b0;
    case (state_r)
      pfde_pkg::ST_CLR_SWEEP: cmd.sweep_step = 1'b1;
      pfde_pkg::ST_IDLE: begin
        cmd.load = accept;
        force_on = accept && (in_req_type == pfde_pkg::REQ_GLYPH);
      end
      pfde_pkg::ST_RMW_RD:  cmd.rmw_rd = 1'b1;
      pfde_pkg::ST_RMW_WR:  cmd.rmw_wr = 1'b1;
      pfde_pkg::ST_FILL_RD: cmd.rmw_rd = !stat.fill_empty;
      pfde_pkg::ST_FILL_WR: begin
        cmd.rmw_wr = 1'b1;
        cmd.fill_next = 1'b1;
      end
      pfde_pkg::ST_GLY_RD:  cmd.rmw_rd = 1'b1;
      pfde_pkg::ST_GLY_WR: begin
        cmd.rmw_wr = gly_cur[0];
        cmd.gly_next = 1'b1;
      end
      pfde_pkg::ST_CLEAR: begin
        cmd.sweep_init = is_sweep_first_r;
        cmd.sweep_step = !is_sweep_first_r;
      end
      pfde_pkg::ST_HDR:     cmd.hdr_emit = !stat.out_busy;
      pfde_pkg::ST_RD_BYTE: cmd.rd_issue = 1'b1;
      pfde_pkg::ST_RD_OUT: begin
        cmd.rd_shift  = !stat.byte_done;
        cmd.word_emit = stat.byte_done && !stat.out_busy;
        cmd.rd_issue  = 1'b0;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfde_pkg::ST_CLR_SWEEP;
      is_sweep_first_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (state_r == pfde_pkg::ST_CLEAR) is_sweep_first_r <= 1'b0;
      else is_sweep_first_r <= 1'b1;
    end
  end

  // new transaction only from idle
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> $past(state_r) == pfde_pkg::ST_IDLE || state_r == pfde_pkg::ST_IDLE)
    else $error("load outside idle");
  // a write is always preceded by its read
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pfde_pkg::ST_RMW_WR) |-> $past(state_r) == pfde_pkg::ST_RMW_RD)
    else $error("write without read");
  // emitting a word never happens with the stall pending
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.word_emit |-> !stat.out_busy)
    else $error("word emitted into full register");
endmodule
`default_nettype wire

FILE: sv/page_framebuffer_draw_engine_unit.sv
`default_nettype none
// pixel: a read, then a write of the target byte; glyph: a read and a gated write per row
// through the last set bit; fill: a read and a write per clipped pixel; clear: writes every store byte
// page readout: a header, then the data words, each byte of a word read in turn
// through the single read port of the frame store; each item waits while the output is stalled
// reset: synchronous active low; a clearing pass of one store byte per cycle
// (1024 bytes by default) runs after reset before the first transaction
module page_framebuffer_draw_engine_unit #(
  parameter int SCREEN_WIDTH  = pfde_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = pfde_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [7:0]  in_x_pos,
  input  wire logic [7:0]  in_y_pos,
  input  wire logic [7:0]  in_rect_width,
  input  wire logic [7:0]  in_rect_height,
  input  wire logic        in_set_on,
  input  wire logic [7:0]  in_top_bits,
  input  wire logic [7:0]  in_bottom_bits,
  input  wire logic        in_msb_first,
  input  wire logic [2:0]  in_page_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_item_kind,
  output logic [63:0]      out_payload,
  output logic             out_last_item
);
  pfde_pkg::cmd_t  cmd;
  pfde_pkg::stat_t stat;
  logic            force_on;
  logic [15:0]     gly_bits;
  logic [15:0]     gly_cur_r;

  // glyph bits in row order, used to skip empty columns and gate writes
  always_comb begin
    gly_bits = {in_bottom_bits, in_top_bits};
    if (in_msb_first) begin
      for (int k = 0; k < 8; k++) begin
        gly_bits[k]     = in_top_bits[7-k];
        gly_bits[k + 8] = in_bottom_bits[7-k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) gly_cur_r <= gly_bits;
    else if (cmd.gly_next) gly_cur_r <= {1'b0, gly_cur_r[15:1]};
  end

  pfde_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_req_type,
    .gly_bits, .gly_cur(gly_cur_r), .stat, .cmd, .force_on
  );

  pfde_datapath #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_dp (
    .clk, .rst_n, .cmd, .stat, .cfg_wr_en, .cfg_wr_data,
    .in_x_pos, .in_y_pos, .in_rect_width, .in_rect_height,
    .in_set_on(in_set_on | force_on), .in_top_bits, .in_bottom_bits, .in_msb_first,
    .in_page_index, .out_valid, .out_stall, .out_item_kind, .out_payload, .out_last_item
  );
endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`default_nettype none
module tb_top;

  localparam int SW = pfde_pkg::SCREEN_WIDTH_DEF;
  localparam int SH = pfde_pkg::SCREEN_HEIGHT_DEF;
  localparam int PAGES = SH / 8;
  localparam int WORDS = SW / 8;
  localparam int CYCLE_LIMIT = 900000;
  localparam int DRAIN_CYCLES = 2200;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_req_type;
  logic [7:0]  in_x_pos;
  logic [7:0]  in_y_pos;
  logic [7:0]  in_rect_width;
  logic [7:0]  in_rect_height;
  logic        in_set_on;
  logic [7:0]  in_top_bits;
  logic [7:0]  in_bottom_bits;
  logic        in_msb_first;
  logic [2:0]  in_page_index;
  logic        out_valid;
  logic        out_stall;
  logic        out_item_kind;
  logic [63:0] out_payload;
  logic        out_last_item;

  page_framebuffer_draw_engine_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_x_pos(in_x_pos), .in_y_pos(in_y_pos),
    .in_rect_width(in_rect_width), .in_rect_height(in_rect_height),
    .in_set_on(in_set_on), .in_top_bits(in_top_bits),
    .in_bottom_bits(in_bottom_bits), .in_msb_first(in_msb_first),
    .in_page_index(in_page_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_item_kind(out_item_kind), .out_payload(out_payload),
    .out_last_item(out_last_item)
  );

  typedef struct {
    logic        kind;
    logic [63:0] data;
    logic        last;
  } page_item_t;

  // shadow framebuffer and register
  logic [7:0]  shadow_fb [PAGES][SW];
  logic [7:0]  shadow_col_offset;
  page_item_t  pending_items[$];
  int          fail_count;
  int          cycle_count;
  int          stall_mode;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= cycle_count[2];
    endcase
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
  end

  // result checker
  always @(posedge clk) begin
    page_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_items.size() == 0) begin
        $error("unexpected result payload %h", out_payload);
        fail_count++;
      end else begin
        want = pending_items.pop_front();
        if (out_item_kind !== want.kind) begin
          $error("item_kind expected %0d actual %0d", want.kind, out_item_kind);
          fail_count++;
        end
        if (out_payload !== want.data) begin
          $error("payload expected %h actual %h", want.data, out_payload);
          fail_count++;
        end
        if (out_last_item !== want.last) begin
          $error("last_item expected %0d actual %0d", want.last, out_last_item);
          fail_count++;
        end
      end
    end
  end

  function automatic void plot_pixel(int x, int y, logic on);
    if (x >= SW || y >= SH) return;
    shadow_fb[y / 8][x][y % 8] = on;
  endfunction

  // draw model: updates the shadow and queues readout items
  function automatic void predict_draw(logic [2:0] req, logic [7:0] x, logic [7:0] y,
                                       logic [7:0] w, logic [7:0] h, logic on,
                                       logic [7:0] top, logic [7:0] bot,
                                       logic msb, logic [2:0] page);
    logic [7:0]  xe;
    logic [7:0]  ye;
    logic [63:0] word;
    page_item_t  it;
    int          bit_idx;
    xe = x + w;
    ye = y + h;
    case (req)
      pfde_pkg::REQ_PIXEL: plot_pixel(x, y, on);
      pfde_pkg::REQ_FILL: begin
        for (int r = y; r < ye && r < SH; r++)
          for (int c = x; c < xe && c < SW; c++) plot_pixel(c, r, on);
      end
      pfde_pkg::REQ_CLEAR: begin
        for (int p = 0; p < PAGES; p++)
          for (int c = 0; c < SW; c++)
            shadow_fb[p][c] = on ? pfde_pkg::BYTE_ONES : 8'h00;
      end
      pfde_pkg::REQ_GLYPH: begin
        for (int r = 0; r < 8; r++) begin
          bit_idx = msb ? 7 - r : r;
          if (top[bit_idx]) plot_pixel(x, y + r, 1'b1);
          if (bot[bit_idx]) plot_pixel(x, y + r + 8, 1'b1);
        end
      end
      pfde_pkg::REQ_READ: begin
        it.kind = 1'b0;
        it.last = 1'b0;
        it.data = {40'h0, pfde_pkg::HDR_PAGE_CMD | {5'h0, page},
                   pfde_pkg::HDR_HIGH_COL | {4'h0, shadow_col_offset[7:4]},
                   {4'h0, shadow_col_offset[3:0]}};
        pending_items.push_back(it);
        for (int k = 0; k < WORDS; k++) begin
          word = '0;
          for (int c = 0; c < 8; c++)
            if (page < PAGES) word[8*c +: 8] = shadow_fb[page][k*8 + c];
          it.kind = 1'b1;
          it.data = word;
          it.last = (k == WORDS - 1);
          pending_items.push_back(it);
        end
      end
      default: ;
    endcase
  endfunction

  // send one transaction, with bursty gaps before it
  task automatic send_request(logic [2:0] req, logic [7:0] x, logic [7:0] y,
                              logic [7:0] w, logic [7:0] h, logic on,
                              logic [7:0] top, logic [7:0] bot,
                              logic msb, logic [2:0] page);
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 12)) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_x_pos       <= x;
    in_y_pos       <= y;
    in_rect_width  <= w;
    in_rect_height <= h;
    in_set_on      <= on;
    in_top_bits    <= top;
    in_bottom_bits <= bot;
    in_msb_first   <= msb;
    in_page_index  <= page;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_draw(req, x, y, w, h, on, top, bot, msb, page);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    go_idle();
    while (pending_items.size() != 0) @(posedge clk);
    while (in_stall) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write while idle
  task automatic write_col_offset(logic [7:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_col_offset = value;
  endtask

  task automatic read_page(logic [2:0] page);
    send_request(pfde_pkg::REQ_READ, 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                 1'($urandom), page);
  endtask

  task automatic test_reset_readout();
    read_page(3'd0);
    read_page(3'd7);
  endtask

  task automatic test_pixels();
    send_request(pfde_pkg::REQ_PIXEL, 8'd0, 8'd0, 0, 0, 1'b1, 0, 0, 0, 0);
    send_request(pfde_pkg::REQ_PIXEL, 8'd127, 8'd63, 0, 0, 1'b1, 0, 0, 0, 0);
    send_request(pfde_pkg::REQ_PIXEL, 8'd128, 8'd5, 0, 0, 1'b1, 0, 0, 0, 0);
    send_request(pfde_pkg::REQ_PIXEL, 8'd5, 8'd255, 0, 0, 1'b1, 0, 0, 0, 0);
    send_request(pfde_pkg::REQ_PIXEL, 8'd0, 8'd0, 0, 0, 1'b0, 0, 0, 0, 0);
    read_page(3'd7);
  endtask

  task automatic test_fills();
    send_request(pfde_pkg::REQ_FILL, 8'd120, 8'd60, 8'd20, 8'd20, 1'b1, 0, 0, 0, 0);
    send_request(pfde_pkg::REQ_FILL, 8'd10, 8'd10, 8'd250, 8'd3, 1'b1, 0, 0, 0, 0);
    send_request(pfde_pkg::REQ_FILL, 8'd3, 8'd3, 8'd0, 8'd9, 1'b1, 0, 0, 0, 0);
    send_request(pfde_pkg::REQ_FILL, 8'd2, 8'd8, 8'd6, 8'd4, 1'b0, 0, 0, 0, 0);
    read_page(3'd1);
  endtask

  task automatic test_glyphs();
    send_request(pfde_pkg::REQ_GLYPH, 8'd40, 8'd3, 0, 0, 0, 8'hA5, 8'h3C, 1'b0, 0);
    send_request(pfde_pkg::REQ_GLYPH, 8'd41, 8'd55, 0, 0, 0, 8'hFF, 8'h81, 1'b1, 0);
    send_request(pfde_pkg::REQ_GLYPH, 8'd200, 8'd0, 0, 0, 0, 8'hFF, 8'hFF, 1'b0, 0);
    // rows past 255 must not wrap onto the top of the screen
    send_request(pfde_pkg::REQ_GLYPH, 8'd42, 8'd250, 0, 0, 0, 8'hFF, 8'hFF, 1'b0, 0);
    read_page(3'd0);
    read_page(3'd6);
  endtask

  task automatic test_clear_and_unknown();
    send_request(pfde_pkg::REQ_CLEAR, 0, 0, 0, 0, 1'b1, 0, 0, 0, 0);
    send_request(3'd5, 8'd1, 8'd1, 0, 0, 1'b0, 0, 0, 0, 0);
    send_request(3'd7, 8'd1, 8'd1, 0, 0, 1'b0, 0, 0, 0, 0);
    read_page(3'd2);
    send_request(pfde_pkg::REQ_CLEAR, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0);
  endtask

  // mostly pixels, readouts, fills and glyphs, fills mostly small; occasional clears and unknown types
  task automatic test_random_mix(int count);
    logic [2:0] req;
    logic [7:0] w;
    logic [7:0] h;
    logic [7:0] x;
    logic [7:0] y;
    int         pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) req = pfde_pkg::REQ_PIXEL;
      else if (pick < 50) req = pfde_pkg::REQ_FILL;
      else if (pick < 52) req = pfde_pkg::REQ_CLEAR;
      else if (pick < 70) req = pfde_pkg::REQ_GLYPH;
      else if (pick < 95) req = pfde_pkg::REQ_READ;
      else req = 3'($urandom_range(5, 7));
      w = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
      h = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
      x = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
      y = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 63));
      send_request(req, x, y, w, h, 1'($urandom), 8'($urandom), 8'($urandom),
                   1'($urandom), 3'($urandom));
    end
  endtask

  task automatic test_col_offsets();
    write_col_offset(8'd0);
    read_page(3'd4);
    write_col_offset(8'd131);
    read_page(3'd5);
    write_col_offset(8'hFF);
    read_page(3'd3);
    write_col_offset(8'($urandom_range(0, 131)));
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_req_type    = pfde_pkg::REQ_PIXEL;
    in_x_pos       = '0;
    in_y_pos       = '0;
    in_rect_width  = '0;
    in_rect_height = '0;
    in_set_on      = 1'b0;
    in_top_bits    = '0;
    in_bottom_bits = '0;
    in_msb_first   = 1'b0;
    in_page_index  = '0;
    out_stall      = 1'b0;
    stall_mode     = 1;
    fail_count     = 0;
    cycle_count    = 0;
    shadow_col_offset = pfde_pkg::COL_OFFSET_RESET;
    for (int p = 0; p < PAGES; p++)
      for (int c = 0; c < SW; c++) shadow_fb[p][c] = 8'h00;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_readout();
    test_pixels();
    test_fills();
    test_glyphs();
    test_clear_and_unknown();
    test_col_offsets();
    test_random_mix(72);
    write_col_offset(8'($urandom_range(0, 131)));
    test_random_mix(71);
    drain_results();

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
sv/pfde_pkg.sv
sv/pfde_datapath.sv
sv/pfde_ctrl.sv
sv/page_framebuffer_draw_engine_unit.sv
bench/tb_top.sv
